[hdl/npl_pkg.sv]
// ----------------------------------------------------------------------------
// npl_pkg
// Shared constants, item types and pipeline structs of the nearest-prototype
// learner.
// ----------------------------------------------------------------------------
`default_nettype none

package npl_pkg;

  // Geometry
  localparam int VECTOR_LEN = 16;
  localparam int MAX_CELLS  = 32;

  localparam int CELL_W = $clog2(MAX_CELLS);
  localparam int ELEM_W = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int CNT_W  = $clog2(VECTOR_LEN + 1);
  localparam int ADDR_W = CELL_W + ELEM_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  // Field widths
  localparam int OP_W     = 2;
  localparam int DATA_W   = 16;
  localparam int IDX_W    = 5;
  localparam int WINNER_W = 5;
  localparam int DIST_W   = 36;
  localparam int ACT_W    = 6;
  localparam int STEP_W   = 16;
  localparam int PROD_W   = 2 * (DATA_W + 1);
  localparam int SQ_W     = 2 * DATA_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_RECALL  = 2'd0,
    OP_TRAIN   = 2'd1,
    OP_IMPLANT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_SEARCH  = 2'd0,
    MODE_TRAIN   = 2'd1,
    MODE_IMPLANT = 2'd2
  } mode_e;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] element;
    logic                     last;
    logic [IDX_W-1:0]         cell_index;
  } in_item_t;

  typedef struct packed {
    logic [WINNER_W-1:0] winner;
    logic [DIST_W-1:0]   min_distance;
  } out_item_t;

  // One memory access travelling through the datapath
  typedef struct packed {
    logic                     valid;
    mode_e                    mode;
    logic [CELL_W-1:0]        cell_id;
    logic [ELEM_W-1:0]        elem;
    logic                     first;
    logic                     last;
    logic                     row_ok;
    logic signed [DATA_W-1:0] x;
  } pipe_tag_t;

  typedef struct packed {
    logic                     we;
    logic                     row_done;
    logic [CELL_W-1:0]        cell_id;
    logic [ELEM_W-1:0]        elem;
    logic signed [DATA_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic s1_busy;
    logic s2_busy;
  } dp_status_t;

endpackage

`default_nettype wire

[hdl/nearest_prototype_learner.sv]
// ----------------------------------------------------------------------------
// nearest_prototype_learner
// Winner-take-all vector quantizer: loads a vector one element per item,
// finds the nearest stored prototype and optionally pulls it toward the input.
// ----------------------------------------------------------------------------
// Operation: an element item is taken whenever the block is idle. A last item
//   runs a search over the n active cells in use, one memory read per cycle;
//   the result is then registered, held back while the previous result still
//   waits; train adds a write-back of the winning row, implant writes one row.
// The input stalls until the search and any write-back or implant are done, so
//   a new vector is not taken before the last one is through.
// Reset: control state clears at once; prototype rows read as zero until first
//   written (per-row valid flags), so no clearing pass is needed.
`default_nettype none

module nearest_prototype_learner (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input items
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire npl_pkg::in_item_t   in_item_i,
  // result items
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      npl_pkg::out_item_t  out_item_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready
);
  import npl_pkg::*;

  localparam logic REG_ACTIVE_CELLS = 1'b0;
  localparam logic REG_LEARN_STEP   = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SEARCH  = 6'b000010,
    ST_RESULT  = 6'b000100,
    ST_TRAIN   = 6'b001000,
    ST_IMPLANT = 6'b010000,
    ST_FLUSH   = 6'b100000
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ACT_W-1:0]  active_cells_q;
  logic [STEP_W-1:0] learn_step_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cells_q <= ACT_W'(32);
      learn_step_q   <= STEP_W'(6554);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ACTIVE_CELLS: active_cells_q <= pwdata[ACT_W-1:0];
        REG_LEARN_STEP:   learn_step_q   <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACTIVE_CELLS: prdata = 32'(active_cells_q);
      REG_LEARN_STEP:   prdata = 32'(learn_step_q);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input vector buffer. Elements past the loaded count read as zero, so the
  // buffer itself never needs clearing.
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_acc;

  logic signed [DATA_W-1:0] vec_buf [VECTOR_LEN];
  logic [CNT_W-1:0]         cnt_q;
  logic [CNT_W-1:0]         vec_cnt_q;
  logic                     cnt_room;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_room   = (cnt_q < CNT_W'(VECTOR_LEN));

  always_ff @(posedge clk_i) begin
    if (in_acc && cnt_room) begin
      vec_buf[cnt_q[ELEM_W-1:0]] <= in_item_i.element;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      vec_cnt_q <= '0;
    end else if (in_acc) begin
      if (in_item_i.last) begin
        vec_cnt_q <= cnt_room ? cnt_q + CNT_W'(1) : cnt_q;
        cnt_q     <= '0;
      end else if (cnt_room) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: walks cell/element addresses through the prototype memory
  // --------------------------------------------------------------------------
  logic [CELL_W-1:0] cell_q, cell_d;
  logic [ELEM_W-1:0] elem_q, elem_d;
  logic [CELL_W-1:0] last_cell_q, last_cell_d;
  logic              train_q, train_d;
  logic [8:0]        act_ext;
  logic              elem_last;
  logic              issue;
  logic              out_load;
  logic              busy;

  logic [MAX_CELLS-1:0] row_valid_q;

  pipe_tag_t           tag;
  wr_req_t             wr;
  dp_status_t          dp_status;
  logic [DATA_W-1:0]   rdata;
  logic [DIST_W-1:0]   best;
  logic [CELL_W-1:0]   win;

  assign act_ext   = 9'(active_cells_q);
  assign elem_last = (elem_q == ELEM_W'(VECTOR_LEN - 1));
  assign busy      = dp_status.s1_busy || dp_status.s2_busy;

  // Out-of-range cell counts: zero counts as one, above capacity as capacity
  always_comb begin
    if (act_ext == 9'd0) begin
      last_cell_d = '0;
    end else if (act_ext > 9'(MAX_CELLS)) begin
      last_cell_d = CELL_W'(MAX_CELLS - 1);
    end else begin
      last_cell_d = CELL_W'(act_ext - 9'd1);
    end
  end

  always_comb begin
    state_d  = state_q;
    cell_d   = cell_q;
    elem_d   = elem_q;
    train_d  = train_q;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_item_i.last) begin
          elem_d = '0;
          if (in_item_i.op == OP_IMPLANT) begin
            // an index beyond the memory writes nothing
            if (9'(in_item_i.cell_index) < 9'(MAX_CELLS)) begin
              cell_d  = CELL_W'(in_item_i.cell_index);
              state_d = ST_IMPLANT;
            end
          end else begin
            cell_d  = '0;
            train_d = (in_item_i.op == OP_TRAIN);
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        issue  = 1'b1;
        elem_d = elem_last ? '0 : elem_q + ELEM_W'(1);
        if (elem_last) begin
          if (cell_q == last_cell_q) begin
            state_d = ST_RESULT;
          end else begin
            cell_d = cell_q + CELL_W'(1);
          end
        end
      end
      ST_RESULT: begin
        // winner is final once the pipe has drained
        if (!busy && (!out_valid_o || !out_stall_i)) begin
          out_load = 1'b1;
          elem_d   = '0;
          cell_d   = win;
          state_d  = train_q ? ST_TRAIN : ST_IDLE;
        end
      end
      ST_TRAIN, ST_IMPLANT: begin
        issue  = 1'b1;
        elem_d = elem_last ? '0 : elem_q + ELEM_W'(1);
        if (elem_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cell_q      <= '0;
      elem_q      <= '0;
      train_q     <= 1'b0;
      last_cell_q <= '0;
    end else begin
      state_q <= state_d;
      cell_q  <= cell_d;
      elem_q  <= elem_d;
      train_q <= train_d;
      if (state_q == ST_IDLE) begin
        last_cell_q <= last_cell_d;
      end
    end
  end

  // Issue tag for the datapath
  always_comb begin
    tag.valid   = issue;
    tag.cell_id = cell_q;
    tag.elem    = elem_q;
    tag.first   = (elem_q == '0);
    tag.last    = elem_last;
    tag.row_ok  = row_valid_q[cell_q];
    tag.x       = (CNT_W'(elem_q) < vec_cnt_q) ? vec_buf[elem_q] : '0;
    case (state_q)
      ST_TRAIN:   tag.mode = MODE_TRAIN;
      ST_IMPLANT: tag.mode = MODE_IMPLANT;
      default:    tag.mode = MODE_SEARCH;
    endcase
  end

  // Row flags go up only after the row's final element is written, so reads
  // still in flight for the same row never see an unwritten entry as valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (wr.we && wr.row_done) begin
      row_valid_q[wr.cell_id] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Prototype memory and datapath
  // --------------------------------------------------------------------------
  npl_ram #(
    .DEPTH (RAM_DEPTH),
    .WIDTH (DATA_W)
  ) u_proto_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i ({wr.cell_id, wr.elem}),
    .wdata_i (wr.data),
    .raddr_i ({cell_q, elem_q}),
    .rdata_o (rdata)
  );

  npl_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (tag),
    .rdata_i      (rdata),
    .learn_step_i (learn_step_q),
    .wr_o         (wr),
    .status_o     (dp_status),
    .best_o       (best),
    .win_o        (win)
  );

  // --------------------------------------------------------------------------
  // Result register; the train write-back runs while the item waits here
  // --------------------------------------------------------------------------
  out_item_t out_q;
  logic      out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.winner       <= WINNER_W'(win);
      out_q.min_distance <= best;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[hdl/npl_ram.sv]
// ----------------------------------------------------------------------------
// npl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module npl_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/npl_datapath.sv]
// ----------------------------------------------------------------------------
// npl_datapath
// Two-stage arithmetic behind the prototype memory: difference and multiply,
// then distance accumulation / winner compare or learning write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module npl_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire npl_pkg::pipe_tag_t         issue_i,
  input  wire logic [npl_pkg::DATA_W-1:0] rdata_i,
  input  wire logic [npl_pkg::STEP_W-1:0] learn_step_i,
  output      npl_pkg::wr_req_t           wr_o,
  output      npl_pkg::dp_status_t        status_o,
  output      logic [npl_pkg::DIST_W-1:0] best_o,
  output      logic [npl_pkg::CELL_W-1:0] win_o
);
  import npl_pkg::*;

  pipe_tag_t s1_q, s2_q;

  logic signed [DATA_W-1:0] v;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W:0]   mul_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [DATA_W-1:0] v_q;

  logic [DIST_W-1:0] acc_q, acc_d;
  logic [DIST_W-1:0] best_q;
  logic [CELL_W-1:0] win_q;
  logic [SQ_W-1:0]   sq;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] dist_cur;

  // Stage 1: read data arrives; rows never written read as zero
  assign v     = s1_q.row_ok ? $signed(rdata_i) : '0;
  assign diff  = {s1_q.x[DATA_W-1], s1_q.x} - {v[DATA_W-1], v};
  assign mul_b = (s1_q.mode == MODE_SEARCH) ? diff : $signed({1'b0, learn_step_i});
  assign prod_d = diff * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= issue_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    v_q    <= v;
  end

  // Stage 2: saturating distance accumulation
  assign sq       = prod_q[SQ_W-1:0];
  assign sum      = {1'b0, acc_q} + (DIST_W+1)'(sq);
  assign dist_cur = s2_q.first ? DIST_W'(sq) : (sum[DIST_W] ? '1 : sum[DIST_W-1:0]);
  assign acc_d    = dist_cur;

  always_ff @(posedge clk_i) begin
    if (s2_q.valid && (s2_q.mode == MODE_SEARCH)) begin
      acc_q <= acc_d;
      if (s2_q.last && ((s2_q.cell_id == '0) || (dist_cur < best_q))) begin
        best_q <= dist_cur;
        win_q  <= s2_q.cell_id;
      end
    end
  end

  // Stage 2: write-back; floor of product / 2^16 is the arithmetic shift
  always_comb begin
    wr_o.we       = s2_q.valid && (s2_q.mode != MODE_SEARCH);
    wr_o.row_done = s2_q.last;
    wr_o.cell_id  = s2_q.cell_id;
    wr_o.elem     = s2_q.elem;
    if (s2_q.mode == MODE_IMPLANT) begin
      wr_o.data = s2_q.x;
    end else begin
      wr_o.data = v_q + $signed(prod_q[STEP_W+DATA_W-1:STEP_W]);
    end
  end

  assign status_o.s1_busy = s1_q.valid;
  assign status_o.s2_busy = s2_q.valid;
  assign best_o = best_q;
  assign win_o  = win_q;

endmodule

`default_nettype wire

[tb/nearest_prototype_learner_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_prototype_learner_tb
// Self-checking bench for the nearest-prototype learner. Streams vectors of
// random and hand-picked items through the valid/stall input channel, keeps
// a bit-exact software copy of the prototype store, and checks every result
// item against it. Both channels idle at random; configuration is rewritten
// over the APB port between phases.
// ----------------------------------------------------------------------------
module nearest_prototype_learner_tb;
  import npl_pkg::*;

  // Register map, one 32-bit word per register
  localparam int REG_ACTIVE_CELLS = 0;
  localparam int REG_LEARN_STEP   = 1;

  // The op encoding the package leaves unnamed; the block treats it as recall
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam int    MAX_GAP       = 18;
  localparam int    SETTLE_CYCLES = 64;   // covers train write-back and implant
  localparam int    RANDOM_ITEMS  = 1050;
  localparam int    NUM_PHASES    = 8;
  localparam int    RAND_PHASE    = 6;
  localparam longint DIST_LIMIT   = (longint'(1) << DIST_W) - 1;

  // --------------------------------------------------------------------------
  // Scoreboard: software copy of the prototype store plus the queue of
  // winner/distance pairs still owed by the block.
  // --------------------------------------------------------------------------
  class quantizer_scoreboard;
    logic signed [DATA_W-1:0] protos [MAX_CELLS][VECTOR_LEN];
    logic signed [DATA_W-1:0] vec_buf [VECTOR_LEN];
    int unsigned              loaded;
    logic [ACT_W-1:0]         active_cells;
    logic [STEP_W-1:0]        learn_step;
    out_item_t                pending_q[$];
    int                       errors;

    function new();
      foreach (protos[c, j]) protos[c][j] = '0;
      foreach (vec_buf[j]) vec_buf[j] = '0;
      loaded       = 0;
      active_cells = ACT_W'(32);
      learn_step   = STEP_W'(6554);
      errors       = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t: mismatch, %s", $time, what);
    endtask

    // Called for every accepted input item
    task note_input(in_item_t it);
      int unsigned n;
      int unsigned best_cell;
      longint      best_sum;
      longint      sum_sq;
      longint      d;
      longint      p;
      out_item_t   res;
      if (loaded < VECTOR_LEN) begin
        vec_buf[loaded] = it.element;
        loaded++;
      end
      if (!it.last) return;

      if (it.op == OP_IMPLANT) begin
        if (it.cell_index < MAX_CELLS) begin
          foreach (vec_buf[j]) protos[it.cell_index][j] = vec_buf[j];
        end
      end else begin
        // zero searches one cell, anything past the store searches all
        if (active_cells == 0) n = 1;
        else if (active_cells > MAX_CELLS) n = MAX_CELLS;
        else n = active_cells;
        best_sum  = 0;
        best_cell = 0;
        for (int c = 0; c < n; c++) begin
          sum_sq = 0;
          for (int j = 0; j < VECTOR_LEN; j++) begin
            d = longint'(vec_buf[j]) - longint'(protos[c][j]);
            sum_sq += d * d;
          end
          if (sum_sq > DIST_LIMIT) sum_sq = DIST_LIMIT;
          // strict less-than keeps the lowest index on ties
          if (c == 0 || sum_sq < best_sum) begin
            best_sum  = sum_sq;
            best_cell = c;
          end
        end
        res.winner       = WINNER_W'(best_cell);
        res.min_distance = DIST_W'(best_sum);
        pending_q.push_back(res);

        if (it.op == OP_TRAIN) begin
          // arithmetic shift of the signed product is the floor division
          for (int j = 0; j < VECTOR_LEN; j++) begin
            p = (longint'(vec_buf[j]) - longint'(protos[best_cell][j]))
                * longint'(learn_step);
            protos[best_cell][j] = DATA_W'(longint'(protos[best_cell][j]) + (p >>> 16));
          end
        end
      end

      foreach (vec_buf[j]) vec_buf[j] = '0;
      loaded = 0;
    endtask

    // Called for every accepted result item
    task check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result winner %0d distance %0d",
                                  got.winner, got.min_distance));
        return;
      end
      want = pending_q.pop_front();
      if (got.winner !== want.winner)
        report_mismatch($sformatf("winner %0d, wanted %0d", got.winner, want.winner));
      if (got.min_distance !== want.min_distance)
        report_mismatch($sformatf("min_distance %0d, wanted %0d",
                                  got.min_distance, want.min_distance));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  quantizer_scoreboard sb;

  int unsigned items_sent = 0;
  bit          tx_idle_on = 1'b1;   // sender inserts random gaps
  bit          rx_idle_on = 1'b1;   // receiver stalls at random
  int unsigned rx_hold = 0;
  bit          rx_drawn = 1'b0;

  nearest_prototype_learner uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Result side. Stall is driven at the falling edge: a fresh draw when a new
  // result shows up, plus occasional stalls while nothing is offered so that
  // valid sometimes rises into an already-stalled channel.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !rx_drawn) begin
        rx_hold  = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        rx_drawn = 1'b1;
      end else if (!out_valid_o && rx_idle_on && rx_hold == 0 &&
                   $urandom_range(0, 15) == 0) begin
        rx_hold = $urandom_range(1, MAX_GAP);
      end
      out_stall_i <= (rx_hold != 0);
      if (rx_hold != 0) rx_hold--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_item_o);
      rx_drawn = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  function automatic in_item_t item_of(logic [OP_W-1:0] op, int element, bit last,
                                       int cell_no);
    in_item_t it;
    it.op         = op;
    it.element    = DATA_W'(element);
    it.last       = last;
    it.cell_index = IDX_W'(cell_no);
    return it;
  endfunction

  // Valid stays high across back-to-back items; a gap lowers it first.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    items_sent++;
  endtask

  // Hold the sender until every owed result is back, then let write-back of
  // a train or an implant finish.
  task automatic wait_results_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write, then read back the same register
  task automatic write_reg(int idx, logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_ACTIVE_CELLS) ? 32'((1 << ACT_W) - 1) : 32'((1 << STEP_W) - 1);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask))
      sb.report_mismatch($sformatf("register %0d reads %0h, wrote %0h",
                                   idx, prdata & mask, value & mask));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_ACTIVE_CELLS) sb.active_cells = ACT_W'(value);
    else sb.learn_step = STEP_W'(value);
  endtask

  // Element styles: 0 uniform, 1 near a stored prototype, 2 extremes,
  // 3 exact copy of a prototype (distance zero, ties when cells repeat)
  function automatic int pick_element(int unsigned style, int unsigned base, int k);
    int v;
    int unsigned r;
    case (style)
      1: begin
        v = int'(sb.protos[base][k % VECTOR_LEN]) + int'($urandom_range(0, 16)) - 8;
      end
      2: begin
        r = $urandom_range(0, 4);
        v = (r == 0) ? 32767 : (r == 1) ? -32768 : (r == 2) ? -1 : (r == 3) ? 1 : 0;
      end
      3: begin
        v = int'(sb.protos[base][k % VECTOR_LEN]);
      end
      default: begin
        v = int'($urandom_range(0, 65535));
      end
    endcase
    return v;
  endfunction

  // Mostly complete vectors; some short, some overlong, some lone noise items
  task automatic send_random_vector();
    int unsigned      shape;
    int unsigned      len;
    int unsigned      style;
    int unsigned      base;
    int unsigned      pick;
    logic [OP_W-1:0]  last_op;
    in_item_t         it;
    shape = $urandom_range(0, 9);
    if (shape < 6) len = VECTOR_LEN;
    else if (shape < 8) len = $urandom_range(1, VECTOR_LEN - 1);
    else if (shape == 8) len = $urandom_range(VECTOR_LEN + 1, VECTOR_LEN + 4);
    else len = 1;
    style = (shape == 9) ? 0 : $urandom_range(0, 3);
    base  = $urandom_range(0, MAX_CELLS - 1);
    pick  = $urandom_range(0, 9);
    if (shape == 9) last_op = OP_W'($urandom_range(0, 3));
    else if (pick < 4) last_op = OP_RECALL;
    else if (pick < 7) last_op = OP_TRAIN;
    else if (pick < 9) last_op = OP_IMPLANT;
    else last_op = OP_RESERVED;
    for (int k = 0; k < len; k++) begin
      // op and cell_index of non-last items are junk the block must ignore
      it = item_of(OP_W'($urandom_range(0, 3)), pick_element(style, base, k), 1'b0,
                   $urandom_range(0, MAX_CELLS - 1));
      if (k == len - 1) begin
        it.last = 1'b1;
        it.op   = last_op;
      end
      send_item(it);
    end
    // now and then let the pipeline run dry before going on
    if ($urandom_range(0, 19) == 0) wait_results_done();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  int phase_cells [NUM_PHASES] = '{1, 32, 0, 63, 33, 7, 1, 32};
  int phase_step  [NUM_PHASES] = '{0, 65535, 32768, 1, 6554, 65535, 0, 12345};

  initial begin
    int unsigned target;
    int          cells;
    int          step;
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset configuration (32 cells, default step).
    // Single-item vector: the rest of the vector counts as zero.
    send_item(item_of(OP_RECALL, 32767, 1'b1, 0));
    // Implant into the top cell
    send_item(item_of(OP_IMPLANT, -32768, 1'b1, 31));
    // Implant op on a non-last item must be ignored
    send_item(item_of(OP_IMPLANT, -32768, 1'b0, 3));
    send_item(item_of(OP_RECALL, -32768, 1'b1, 0));
    // Train on an exact match: zero distance, no movement
    send_item(item_of(OP_TRAIN, -32768, 1'b1, 0));
    // Reserved op behaves as recall; all-zero vector ties across zero cells
    send_item(item_of(OP_RESERVED, 0, 1'b1, 31));
    // Overlong vector: the extra element is dropped
    for (int k = 0; k <= VECTOR_LEN; k++)
      send_item(item_of(OP_RECALL, (k % 2) ? -32768 : 32767, k == VECTOR_LEN, 0));
    send_item(item_of(OP_TRAIN, 32767, 1'b1, 0));

    // Random phases, each with its own configuration and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_results_done();
      cells = (p == RAND_PHASE) ? $urandom_range(1, MAX_CELLS) : phase_cells[p];
      step  = (p == RAND_PHASE) ? $urandom_range(0, 65535) : phase_step[p];
      write_reg(REG_ACTIVE_CELLS, 32'(cells));
      write_reg(REG_LEARN_STEP, 32'(step));
      tx_idle_on = (p % 4 != 1);
      rx_idle_on = (p % 3 != 2);
      target = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < target) send_random_vector();
    end

    wait_results_done();
    if (sb.errors == 0) begin
      $display("nearest_prototype_learner_tb OK");
    end else begin
      $display("nearest_prototype_learner_tb NOT OK");
    end
    $finish;
  end

  // Worst case is far below this: every item a full search of all cells
  // with maximum gaps and stalls still ends well before the timeout.
  initial begin
    #30_000_000;
    $display("nearest_prototype_learner_tb NOT OK");
    $finish;
  end

endmodule
